/* hdl/spq_pkg.sv */
// Shared types, codes and helpers for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned TAG_W     = 9;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned CNT_OUT_W = 9;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [WEIGHT_W-1:0] weight;
    logic [TAG_W-1:0]    tag;
    logic [POS_W-1:0]    position;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WEIGHT_W-1:0]  out_weight;
    logic [TAG_W-1:0]     out_tag;
    logic [CNT_OUT_W-1:0] count;
    logic                 is_empty;
  } spq_rsp_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [TAG_W-1:0]    tag;
  } spq_entry_t;

  // registered levels of a fan-in-4 tree over n leaves
  function automatic int unsigned spq_levels(input int unsigned n);
    return ($clog2(n) + 1) / 2;
  endfunction

endpackage

/* hdl/spq_cell.sv */
// One slot of the sorted array: holds an entry, shifts right on insert.
`timescale 1ns / 1ps

module spq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9,
  parameter int unsigned IW  = 8
) (
  input  logic                clk,
  input  logic                ins,
  input  logic [CW-1:0]       count,
  input  logic [IW-1:0]       sel,
  input  spq_pkg::spq_entry_t new_ent,
  input  spq_pkg::spq_entry_t left,
  input  logic                left_gt,
  output spq_pkg::spq_entry_t ent,
  output logic                gt,
  output spq_pkg::spq_entry_t rd
);

  localparam logic [CW-1:0] MY_POS = CW'(IDX);
  localparam logic [IW-1:0] MY_SEL = IW'(IDX);

  // gt is a run of ones from the head over the occupied cells whose weight exceeds the new weight
  assign gt = (MY_POS < count) && (ent.weight > new_ent.weight);
  assign rd = (sel == MY_SEL) ? ent : '0;

  always_ff @(posedge clk) begin
    if (ins && !gt) begin
      if (left_gt) begin
        ent <= new_ent;
      end else begin
        ent <= left;
      end
    end
  end

endmodule

/* hdl/spq_or_tree.sv */
// Registered fan-in-4 OR tree that collects the one selected cell.
`timescale 1ns / 1ps

module spq_or_tree #(
  parameter int unsigned N = 256,
  parameter int unsigned W = 41
) (
  input  logic           clk,
  input  logic [N*W-1:0] leaf,
  output logic [W-1:0]   root
);

  localparam int unsigned LV = spq_pkg::spq_levels(N);
  localparam int unsigned PN = 1 << (2 * LV);
  localparam int unsigned NT = (PN - 1) / 3;

  function automatic int unsigned base(input int unsigned l);
    int unsigned b;
    b = 0;
    for (int unsigned k = 1; k < l; k++) begin
      b = b + (1 << (2 * (LV - k)));
    end
    return b;
  endfunction

  logic [PN*W-1:0] pad;
  logic [NT*W-1:0] node;
  logic [NT*W-1:0] node_next;

  assign pad = (PN*W)'(leaf);

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    localparam int unsigned B  = base(l);
    localparam int unsigned PB = base(l - 1);
    for (genvar n = 0; n < (1 << (2 * (LV - l))); n++) begin : g_node
      if (l == 1) begin : g_first
        assign node_next[(B+n)*W +: W] = pad[(4*n)*W +: W] | pad[(4*n+1)*W +: W]
                                       | pad[(4*n+2)*W +: W] | pad[(4*n+3)*W +: W];
      end else begin : g_upper
        assign node_next[(B+n)*W +: W] = node[(PB+4*n)*W +: W] | node[(PB+4*n+1)*W +: W]
                                       | node[(PB+4*n+2)*W +: W] | node[(PB+4*n+3)*W +: W];
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
  end

  assign root = node[(NT-1)*W +: W];

endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue: a row of cells kept in descending weight order.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------
//   req     | in        | req_valid, req_stall | spq_pkg::spq_req_t
//   rsp     | out       | rsp_valid, rsp_stall | spq_pkg::spq_rsp_t
//
// Insert: all cells compare against the new weight at once; the row shifts on the accepting
// edge and the response loads there too when the output is free, so one item per cycle while rsp_stall is low.
// Remove and read: the selected cell index is registered, its entry passes the LV registered levels of the OR tree,
// LV = ceil(log4(DEPTH)), and no new request is taken until the response has loaded or is held.
// rst is synchronous and clears the count; cell contents are not reset.
// A stalled response holds; one further request may finish into a holding slot.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  spq_pkg::spq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output spq_pkg::spq_rsp_t rsp
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned EW   = $bits(spq_pkg::spq_entry_t);
  localparam int unsigned LV   = spq_pkg::spq_levels(DEPTH);
  localparam int unsigned CNTW = $clog2(LV + 1);
  localparam int unsigned CMPW = (CW > spq_pkg::POS_W) ? CW : spq_pkg::POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                  state;
  logic [CNTW-1:0]             cnt;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [IW-1:0]               sel;
  logic [IW-1:0]               sel_next;
  spq_pkg::spq_rsp_t           res;
  spq_pkg::spq_rsp_t           pend;
  spq_pkg::spq_rsp_t           tree_rsp;
  logic                        pend_tree;
  logic                        use_tree;
  logic                        ins_ok;
  logic                        accept;
  logic                        free;
  logic                        tree_done;
  logic                        load_out;
  logic                        full;
  logic                        empty;
  logic                        rd_ok;
  logic [spq_pkg::POS_W-1:0]   pos_idx;
  spq_pkg::spq_entry_t         new_ent;
  spq_pkg::spq_entry_t         ents [DEPTH];
  logic [DEPTH-1:0]            gts;
  logic [DEPTH*EW-1:0]         leaf;
  spq_pkg::spq_entry_t         root;

  assign accept    = req_valid && (state == S_IDLE);
  assign req_stall = (state != S_IDLE);
  assign free      = !rsp_valid || !rsp_stall;
  assign tree_done = (state == S_BUSY) && (cnt == CNTW'(LV));
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos_idx   = (req.position == '0) ? '0 : req.position - 1'b1;
  assign rd_ok     = CMPW'(pos_idx) < CMPW'(count);
  assign new_ent   = '{weight: req.weight, tag: req.tag};

  always_comb begin
    res        = '0;
    count_next = count;
    sel_next   = sel;
    use_tree   = 1'b0;
    ins_ok     = 1'b0;
    case (req.req_type)
      spq_pkg::REQ_INSERT: begin
        if (full) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::REQ_REMOVE: begin
        if (empty) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
          sel_next   = IW'(count - 1'b1);
          use_tree   = 1'b1;
        end
      end
      spq_pkg::REQ_READ: begin
        if (!rd_ok) begin
          res.status = spq_pkg::ST_RANGE;
        end else begin
          sel_next = IW'(pos_idx);
          use_tree = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count    = spq_pkg::CNT_OUT_W'(count_next);
    res.is_empty = (count_next == '0);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell #(
      .IDX (i),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk     (clk),
      .ins     (accept && ins_ok),
      .count   (count),
      .sel     (sel),
      .new_ent (new_ent),
      .left    ((i == 0) ? new_ent : ents[(i == 0) ? 0 : i-1]),
      .left_gt ((i == 0) ? 1'b1 : gts[(i == 0) ? 0 : i-1]),
      .ent     (ents[i]),
      .gt      (gts[i]),
      .rd      (leaf[i*EW +: EW])
    );
  end

  spq_or_tree #(
    .N (DEPTH),
    .W (EW)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  assign load_out = free && ((accept && !use_tree) || tree_done || (state == S_HOLD));

  // held response, with the selected entry merged in for remove and read
  always_comb begin
    tree_rsp = pend;
    if (pend_tree) begin
      tree_rsp.out_weight = root.weight;
      tree_rsp.out_tag    = root.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            cnt   <= '0;
            if (use_tree) begin
              state <= S_BUSY;
            end else if (!free) begin
              state <= S_HOLD;
            end
          end
        end
        S_BUSY: begin
          if (tree_done) begin
            state <= free ? S_IDLE : S_HOLD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_HOLD: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend      <= res;
      pend_tree <= use_tree;
      sel       <= sel_next;
    end
    if (load_out) begin
      if (state == S_IDLE) begin
        rsp <= res;
      end else begin
        rsp <= tree_rsp;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (req.req_type == spq_pkg::REQ_INSERT) && !full
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY) |-> cnt <= CNTW'(LV))
    else $error("tree wait counter overran");

  a_sel_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY) |-> CW'(sel) <= count)
    else $error("selected cell outside the held entries");
`endif

endmodule

/* sim/spq_checker.sv */
// Checker for the sorted priority queue: tracks the queue contents and compares every response.
`timescale 1ns / 1ps

module spq_checker #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  spq_pkg::spq_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  spq_pkg::spq_rsp_t rsp,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                held,
  output int                peak
);

  // shadow of the sorted row, head at index 0
  logic [spq_pkg::WEIGHT_W-1:0] row_weight [DEPTH];
  logic [spq_pkg::TAG_W-1:0]    row_tag    [DEPTH];
  int unsigned                  row_len = 0;

  spq_pkg::spq_rsp_t rsp_due [$];

  task automatic apply_request(input spq_pkg::spq_req_t r, output spq_pkg::spq_rsp_t res);
    int unsigned slot;
    int unsigned idx;
    int unsigned k;
    res = '0;
    res.status = spq_pkg::ST_OK;
    case (r.req_type)
      spq_pkg::REQ_INSERT: begin
        if (row_len >= DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          slot = 0;
          while (slot < row_len && row_weight[slot] > r.weight) slot++;
          for (k = row_len; k > slot; k--) begin
            row_weight[k] = row_weight[k-1];
            row_tag[k]    = row_tag[k-1];
          end
          row_weight[slot] = r.weight;
          row_tag[slot]    = r.tag;
          row_len++;
        end
      end
      spq_pkg::REQ_REMOVE: begin
        if (row_len == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          row_len--;
          res.out_weight = row_weight[row_len];
          res.out_tag    = row_tag[row_len];
        end
      end
      spq_pkg::REQ_READ: begin
        idx = (r.position == '0) ? 0 : int'(r.position) - 1;
        if (idx >= row_len) begin
          res.status = spq_pkg::ST_RANGE;
        end else begin
          res.out_weight = row_weight[idx];
          res.out_tag    = row_tag[idx];
        end
      end
      default: ;  // unused code: queue untouched
    endcase
    res.count    = spq_pkg::CNT_OUT_W'(row_len);
    res.is_empty = (row_len == 0);
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    spq_pkg::spq_rsp_t want;
    spq_pkg::spq_rsp_t res;
    if (rst) begin
      row_len = 0;
      errors  = 0;
      checked = 0;
      rsp_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        checked++;
        if (rsp_due.size() == 0) begin
          errors++;
          $display("%0d ns: response with nothing expected, actual 0x%0h", $time, rsp);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.status !== want.status)         report("status", want.status, rsp.status);
          if (rsp.out_weight !== want.out_weight) report("out_weight", want.out_weight,
                                                         rsp.out_weight);
          if (rsp.out_tag !== want.out_tag)       report("out_tag", want.out_tag, rsp.out_tag);
          if (rsp.count !== want.count)           report("count", want.count, rsp.count);
          if (rsp.is_empty !== want.is_empty)     report("is_empty", want.is_empty,
                                                         rsp.is_empty);
        end
      end
      if (req_valid && !req_stall) begin
        apply_request(req, res);
        rsp_due.push_back(res);
      end
    end
    held    <= row_len;
    pending <= rsp_due.size();
    if (row_len > peak) peak <= row_len;
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the sorted priority queue: clock, reset, requests and the verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QDEPTH = spq_pkg::DEPTH_DEF;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  spq_pkg::spq_req_t req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  spq_pkg::spq_rsp_t rsp;

  logic calm = 1'b0;  // no gaps and no stalls while set
  int   sent = 0;
  int   errors, pending, checked, held, peak;

  sorted_priority_queue #(.DEPTH(QDEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  spq_checker #(.DEPTH(QDEPTH)) chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .held      (held),
    .peak      (peak)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : stall_gen
    int n;
    int seg;
    if (rst || calm) begin
      rsp_stall <= 1'b0;
      seg = 0;
    end else if (seg > 1) begin
      seg--;
    end else begin
      n = idle_len();
      if (n == 0) begin
        rsp_stall <= 1'b0;
        seg = 1 + $urandom_range(0, 8);
      end else begin
        rsp_stall <= 1'b1;
        seg = n;
      end
    end
  end

  function automatic spq_pkg::spq_req_t make_req(logic [1:0] op, logic [31:0] w,
                                                 logic [8:0] t, logic [8:0] p);
    spq_pkg::spq_req_t r;
    r.req_type = op;
    r.weight   = w;
    r.tag      = t;
    r.position = p;
    return r;
  endfunction

  // ties are common on purpose: the small range collides often
  function automatic logic [31:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 7);
    if (r < 50) return 32'h0;
    if (r < 60) return 32'hFFFF_FFFF;
    if (r < 70) return 32'hFFFF_FFF8 + $urandom_range(0, 7);
    return $urandom;
  endfunction

  function automatic logic [8:0] rand_pos(int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 9'($urandom_range(0, n + 2));
    if (r < 85) return 9'($urandom_range(0, 511));
    return 9'(n + $urandom_range(0, 1));
  endfunction

  function automatic spq_pkg::spq_req_t rand_req();
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < 47)      op = spq_pkg::REQ_INSERT;
    else if (r < 77) op = spq_pkg::REQ_REMOVE;
    else if (r < 97) op = spq_pkg::REQ_READ;
    else             op = spq_pkg::REQ_UNUSED;
    return make_req(op, rand_weight(), 9'($urandom_range(0, 511)), rand_pos(held));
  endfunction

  // one transfer on the request channel
  task automatic send(spq_pkg::spq_req_t item);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, ties, weight extremes, range edges
    send(make_req(spq_pkg::REQ_REMOVE, 32'h0, 9'h0, 9'h0));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd0));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd1));
    send(make_req(spq_pkg::REQ_UNUSED, 32'hA5A5_5A5A, 9'h1FF, 9'h1FF));
    send(make_req(spq_pkg::REQ_INSERT, 32'd5, 9'd1, 9'h0));
    send(make_req(spq_pkg::REQ_INSERT, 32'd5, 9'd2, 9'h0));
    send(make_req(spq_pkg::REQ_INSERT, 32'h0, 9'h0, 9'h0));
    send(make_req(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF));
    send(make_req(spq_pkg::REQ_INSERT, 32'd5, 9'd3, 9'h0));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd0));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd1));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd2));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd5));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd6));
    send(make_req(spq_pkg::REQ_READ, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF));
    send(make_req(spq_pkg::REQ_UNUSED, 32'h0, 9'h0, 9'd0));
    send(make_req(spq_pkg::REQ_REMOVE, 32'h0, 9'h0, 9'h0));
    send(make_req(spq_pkg::REQ_REMOVE, 32'h0, 9'h0, 9'h0));
    send(make_req(spq_pkg::REQ_REMOVE, 32'h0, 9'h0, 9'h0));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd1));
    send(make_req(spq_pkg::REQ_REMOVE, 32'h0, 9'h0, 9'h0));
    send(make_req(spq_pkg::REQ_REMOVE, 32'h0, 9'h0, 9'h0));
    send(make_req(spq_pkg::REQ_REMOVE, 32'h0, 9'h0, 9'h0));

    // random mix with idling, then a stretch at full rate
    repeat (40) send(rand_req());
    calm <= 1'b1;
    repeat (20) send(rand_req());
    calm <= 1'b0;

    // fill to capacity, push past it, probe the last slots, then drain past empty
    wait_drained();
    n = QDEPTH - held + 4;
    repeat (n) send(make_req(spq_pkg::REQ_INSERT, rand_weight(), 9'($urandom_range(0, 511)),
                             9'($urandom_range(0, 511))));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'(QDEPTH)));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'(QDEPTH + 1)));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'd0));
    send(make_req(spq_pkg::REQ_READ, 32'h0, 9'h0, 9'h1FF));
    send(make_req(spq_pkg::REQ_UNUSED, $urandom, 9'($urandom_range(0, 511)),
                  9'($urandom_range(0, 511))));
    repeat (QDEPTH + 2) send(make_req(spq_pkg::REQ_REMOVE, $urandom,
                                      9'($urandom_range(0, 511)),
                                      9'($urandom_range(0, 511))));

    repeat (20) send(rand_req());

    wait_drained();
    $display("Sent %0d requests (directed, random mix, fill to full and drain past empty);",
             sent);
    $display("checked %0d responses, peak occupancy %0d of %0d.", checked, peak, QDEPTH);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
